// ===== design/quadratic_root_solver_core_macros.svh =====
// ----------------------------------------------------------------------------
// Quadratic root solver assertion macros
// Concurrent assertion helpers that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_CORE_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define QRS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qrs assertion failed");
`define QRS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qrs assertion failed");
`else
`define QRS_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define QRS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== design/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Result kinds, pipeline stage types and the per-step arithmetic functions.
// ----------------------------------------------------------------------------
package qrs_pkg;

   typedef enum logic [2:0] {
      KIND_QUIT,
      KIND_NOT_QUAD,
      KIND_DOUBLE,
      KIND_TWO_REAL,
      KIND_COMPLEX
   } kind_type;

   localparam int SQ_STAGES = 16;
   localparam int SQ_STEPS  = 2;
   localparam int DV_STAGES = 11;
   localparam int DV_STEPS  = 3;

   localparam logic signed [34:0] Q_MAX = 35'sd2147483647;
   localparam logic signed [34:0] Q_MIN = -35'sd2147483648;

   typedef struct packed {
      kind_type           kind;
      logic signed [15:0] a;
      logic signed [31:0] nb;
   } side_type;

   typedef struct packed {
      logic        valid;
      side_type    side;
      logic [63:0] rad;
      logic [33:0] rem;
      logic [31:0] root;
   } sq_type;

   typedef struct packed {
      logic [32:0] num;
      logic [15:0] rem;
      logic [32:0] quo;
      logic        neg;
   } lane_type;

   typedef struct packed {
      logic     valid;
      kind_type kind;
      logic [15:0] dvs;
      lane_type one;
      lane_type two;
   } dv_type;

   typedef struct packed {
      logic [31:0] val;
      logic        sat;
   } clip_type;

   function automatic sq_type sq_step(sq_type s);
      sq_type      r;
      logic [35:0] rem_n;
      logic [35:0] trial;
      r = s;
      rem_n = {s.rem, s.rad[63:62]};
      trial = {2'b00, s.root, 2'b01};
      r.rad = {s.rad[61:0], 2'b00};
      if (rem_n >= trial) begin
         r.rem  = 34'(rem_n - trial);
         r.root = {s.root[30:0], 1'b1};
      end else begin
         r.rem  = rem_n[33:0];
         r.root = {s.root[30:0], 1'b0};
      end
      return r;
   endfunction

   function automatic lane_type dv_step(lane_type l, logic [15:0] dvs);
      lane_type    r;
      logic [16:0] rem_n;
      r = l;
      rem_n = {l.rem, l.num[32]};
      r.num = {l.num[31:0], 1'b0};
      if (rem_n >= {1'b0, dvs}) begin
         r.rem = 16'(rem_n - {1'b0, dvs});
         r.quo = {l.quo[31:0], 1'b1};
      end else begin
         r.rem = rem_n[15:0];
         r.quo = {l.quo[31:0], 1'b0};
      end
      return r;
   endfunction

   function automatic clip_type clip_q(lane_type l);
      clip_type           r;
      logic signed [34:0] q;
      q = l.neg ? -$signed({2'b00, l.quo}) : $signed({2'b00, l.quo});
      if (q > Q_MAX) begin
         r.val = Q_MAX[31:0];
         r.sat = 1'b1;
      end else if (q < Q_MIN) begin
         r.val = Q_MIN[31:0];
         r.sat = 1'b1;
      end else begin
         r.val = q[31:0];
         r.sat = 1'b0;
      end
      return r;
   endfunction

endpackage

// ===== design/quadratic_root_solver_core.sv =====
// An item passes input, multiply, square root, divider and result registers.
// Throughput: one item per cycle unless stalled; the square root takes two
// bits per stage over 16 stages and each divider three quotient bits per stage
// over 11. A stalled result stalls the whole pipeline; nothing is dropped.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// Quadratic root solver core
// Pipelined discriminant, integer square root and two signed dividers.
// ----------------------------------------------------------------------------
`include "quadratic_root_solver_core_macros.svh"

module quadratic_root_solver_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_coef_a,
   input  logic signed [15:0] req_coef_b,
   input  logic signed [15:0] req_coef_c,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_root_kind,
   output logic signed [31:0] rsp_root_one,
   output logic signed [31:0] rsp_root_two,
   output logic               rsp_saturated
);
   import qrs_pkg::*;

   logic adv;

   logic               in_valid_ff;
   logic signed [15:0] in_a_ff, in_b_ff, in_c_ff;

   logic               mul_valid_ff;
   logic signed [15:0] mul_a_ff, mul_b_ff;
   logic               mul_c_zero_ff;
   logic signed [31:0] mul_bb_ff, mul_ac_ff;

   logic signed [33:0] d_in;
   logic signed [31:0] nb_in;
   sq_type             sq0_in;
   sq_type             sq_ff [0:SQ_STAGES];

   logic signed [33:0] nbx, n1, n2;
   dv_type             dv0_in;
   dv_type             dv_ff [0:DV_STAGES];

   clip_type           c1, c2;
   logic               rsp_valid_ff;
   logic [2:0]         rsp_kind_ff, rsp_kind_in;
   logic [31:0]        rsp_one_ff, rsp_one_in, rsp_two_ff, rsp_two_in;
   logic               rsp_sat_ff, rsp_sat_in;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mul_valid_ff <= 1'b0;
      end else if (adv) begin
         in_valid_ff  <= req_valid;
         mul_valid_ff <= in_valid_ff;
      end
      if (adv) begin
         in_a_ff       <= req_coef_a;
         in_b_ff       <= req_coef_b;
         in_c_ff       <= req_coef_c;
         mul_a_ff      <= in_a_ff;
         mul_b_ff      <= in_b_ff;
         mul_c_zero_ff <= (in_c_ff == 16'sd0);
         mul_bb_ff     <= in_b_ff * in_b_ff;
         mul_ac_ff     <= in_a_ff * in_c_ff;
      end
   end

   always_comb begin
      d_in  = {{2{mul_bb_ff[31]}}, mul_bb_ff} - {mul_ac_ff, 2'b00};
      nb_in = -($signed({mul_b_ff[15], mul_b_ff, 15'b000000000000000}));
      sq0_in.valid   = mul_valid_ff;
      sq0_in.side.a  = mul_a_ff;
      sq0_in.side.nb = nb_in;
      sq0_in.rem     = '0;
      sq0_in.root    = '0;
      sq0_in.rad     = (d_in > 34'sd0) ? {1'b0, d_in[32:0], 30'b0} : 64'b0;
      if (mul_a_ff == 16'sd0 && mul_b_ff == 16'sd0 && mul_c_zero_ff) begin
         sq0_in.side.kind = KIND_QUIT;
      end else if (mul_a_ff == 16'sd0) begin
         sq0_in.side.kind = KIND_NOT_QUAD;
      end else if (d_in > 34'sd0) begin
         sq0_in.side.kind = KIND_TWO_REAL;
      end else if (d_in == 34'sd0) begin
         sq0_in.side.kind = KIND_DOUBLE;
      end else begin
         sq0_in.side.kind = KIND_COMPLEX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff[0].valid <= 1'b0;
      end else if (adv) begin
         sq_ff[0] <= sq0_in;
      end
   end

   for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sq
      sq_type stage_in;
      always_comb begin
         stage_in = sq_ff[g];
         for (int k = 0; k < SQ_STEPS; k++) begin
            stage_in = sq_step(stage_in);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_ff[g+1].valid <= 1'b0;
         end else if (adv) begin
            sq_ff[g+1] <= stage_in;
         end
      end
   end

   always_comb begin
      nbx = {{2{sq_ff[SQ_STAGES].side.nb[31]}}, sq_ff[SQ_STAGES].side.nb};
      n1  = nbx + $signed({2'b00, sq_ff[SQ_STAGES].root});
      n2  = nbx - $signed({2'b00, sq_ff[SQ_STAGES].root});
      dv0_in.valid   = sq_ff[SQ_STAGES].valid;
      dv0_in.kind    = sq_ff[SQ_STAGES].side.kind;
      dv0_in.dvs     = sq_ff[SQ_STAGES].side.a[15] ? 16'(-sq_ff[SQ_STAGES].side.a)
                                                   : sq_ff[SQ_STAGES].side.a;
      dv0_in.one.num = n1[33] ? 33'(-n1) : n1[32:0];
      dv0_in.one.neg = n1[33] ^ sq_ff[SQ_STAGES].side.a[15];
      dv0_in.one.rem = '0;
      dv0_in.one.quo = '0;
      dv0_in.two.num = n2[33] ? 33'(-n2) : n2[32:0];
      dv0_in.two.neg = n2[33] ^ sq_ff[SQ_STAGES].side.a[15];
      dv0_in.two.rem = '0;
      dv0_in.two.quo = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0].valid <= 1'b0;
      end else if (adv) begin
         dv_ff[0] <= dv0_in;
      end
   end

   for (genvar g = 0; g < DV_STAGES; g++) begin : g_dv
      dv_type stage_in;
      always_comb begin
         stage_in = dv_ff[g];
         for (int k = 0; k < DV_STEPS; k++) begin
            stage_in.one = dv_step(stage_in.one, stage_in.dvs);
            stage_in.two = dv_step(stage_in.two, stage_in.dvs);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[g+1].valid <= 1'b0;
         end else if (adv) begin
            dv_ff[g+1] <= stage_in;
         end
      end
   end

   always_comb begin
      c1          = clip_q(dv_ff[DV_STAGES].one);
      c2          = clip_q(dv_ff[DV_STAGES].two);
      rsp_kind_in = dv_ff[DV_STAGES].kind;
      case (dv_ff[DV_STAGES].kind)
         KIND_TWO_REAL: begin
            rsp_one_in = c1.val;
            rsp_two_in = c2.val;
            rsp_sat_in = c1.sat | c2.sat;
         end
         KIND_DOUBLE, KIND_COMPLEX: begin
            rsp_one_in = c1.val;
            rsp_two_in = '0;
            rsp_sat_in = c1.sat;
         end
         default: begin
            rsp_one_in = '0;
            rsp_two_in = '0;
            rsp_sat_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_ff[DV_STAGES].valid;
      end
      if (adv) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_one_ff  <= rsp_one_in;
         rsp_two_ff  <= rsp_two_in;
         rsp_sat_ff  <= rsp_sat_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_root_kind = rsp_kind_ff;
   assign rsp_root_one  = rsp_one_ff;
   assign rsp_root_two  = rsp_two_ff;
   assign rsp_saturated = rsp_sat_ff;

   `QRS_ASSERT_IMPLY(a_stall_blocks_input, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   `QRS_ASSERT_IMPLY(a_two_only_for_real, clock, reset, rsp_valid && rsp_root_kind != KIND_TWO_REAL, rsp_root_two == 32'sd0)
   `QRS_ASSERT_IMPLY(a_trivial_kinds_zero, clock, reset, rsp_valid && (rsp_root_kind == KIND_QUIT || rsp_root_kind == KIND_NOT_QUAD), rsp_root_one == 32'sd0 && !rsp_saturated)
   `QRS_ASSERT_IMPLY(a_sat_at_limit, clock, reset, rsp_valid && rsp_saturated, rsp_root_one == Q_MAX[31:0] || rsp_root_one == Q_MIN[31:0] || rsp_root_two == Q_MAX[31:0] || rsp_root_two == Q_MIN[31:0])

endmodule
